### sv/msbp_pkg.sv
// Shared types, widths and helpers for the maximum-sum board path block.
package msbp_pkg;

	localparam int CFG_W      = 7;
	localparam int VALUE_W    = 16;
	localparam int SUM_W      = 32;
	localparam int COL_OUT_W  = 7;
	localparam int RESET_SIZE = 8;

	typedef logic [CFG_W-1:0]         cfg_t;
	typedef logic signed [VALUE_W-1:0] value_t;
	typedef logic signed [SUM_W-1:0]   sum_t;
	typedef logic [COL_OUT_W-1:0]     col_out_t;

	// signed maximum, first argument kept on a tie
	function automatic sum_t smax(input sum_t a, input sum_t b);
		return (b > a) ? b : a;
	endfunction

endpackage

### sv/msbp_if.sv
// Valid/ready channel interfaces for board cells and board results.
interface msbp_cell_if;
	logic            valid;
	logic            ready;
	msbp_pkg::value_t cell_value;

	modport source(output valid, output cell_value, input ready);
	modport sink(input valid, input cell_value, output ready);
endinterface

interface msbp_result_if;
	logic              valid;
	logic              ready;
	msbp_pkg::sum_t     best_sum;
	msbp_pkg::col_out_t best_column;

	modport source(output valid, output best_sum, output best_column, input ready);
	modport sink(input valid, input best_sum, input best_column, output ready);
endinterface

### sv/max_sum_board_path_dp.sv
// Maximum-sum falling path over a square board: one cell per transaction.
// Usage: write board_size through cfg_wr_en/cfg_wr_data while idle; any write
// restarts the board in progress (0 acts as 1, sizes above MAX_SIZE as MAX_SIZE).
// Stream cells in row-major order on cell_in; one result transaction on
// result_out follows the last cell of each board with the largest last-row
// sum and its 1-based column (0 and column 0 when no sum is positive).
// Throughput: one cell per cycle while no waiting result holds the compute stage, set by
// the row-sum memory, which serves two reads (columns c and c+1) and one write
// (column c) each cycle; column c-1 comes from a register holding the previous read.
// The board's last cell is registered into the compute stage, its result into the output register.
// A stalled receiver holds the result in the output register; cells keep
// flowing until the next board's last cell reaches the compute stage, which
// then holds and drops cell_in.ready.
// Reset: board size 8 (MAX_SIZE if smaller), first row and column, running best zero. The row-sum
// memory needs no clearing; first-row cells ignore what they read from it.
module max_sum_board_path_dp #(
	parameter int MAX_SIZE = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  msbp_pkg::cfg_t       cfg_wr_data,
	msbp_cell_if.sink            cell_in,
	msbp_result_if.source        result_out
);

	localparam int CW       = $clog2(MAX_SIZE + 1);
	localparam int AW       = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
	localparam int RST_SIZE = (msbp_pkg::RESET_SIZE > MAX_SIZE) ? MAX_SIZE
		: msbp_pkg::RESET_SIZE;

	typedef logic [CW-1:0] cnt_t;

	typedef struct packed {
		logic first_row;
		logic last_row;
		logic last_col;
		cnt_t col;
	} s1_ctrl_t;

	cnt_t              size_q;
	cnt_t              col_q;
	cnt_t              row_q;
	cnt_t              eff_size;
	cnt_t              col_inc;
	cnt_t              size_m1;
	logic              first_row_now;
	logic              last_row_now;
	logic              last_col_now;
	logic              in_fire;
	logic              advance;
	logic              s1_end;
	logic [AW-1:0]     rd_addr_a;
	logic [AW-1:0]     rd_addr_b;
	logic [AW-1:0]     wr_addr;

	logic              s1_valid_q;
	s1_ctrl_t          ctrl_s1;
	msbp_pkg::value_t  value_s1;
	msbp_pkg::sum_t    rd_a_s1;
	msbp_pkg::sum_t    rd_b_s1;
	msbp_pkg::sum_t    left_q;

	msbp_pkg::sum_t    best_q;
	cnt_t              best_col_q;
	msbp_pkg::sum_t    new_best;
	cnt_t              new_col;
	msbp_pkg::sum_t    above_left;
	msbp_pkg::sum_t    above_right;
	msbp_pkg::sum_t    cell_sum;

	logic              out_valid_q;
	msbp_pkg::sum_t    out_sum_q;
	cnt_t              out_col_q;

	msbp_pkg::sum_t    row_mem [MAX_SIZE];

	always_comb begin
		if (cfg_wr_data == '0) begin
			eff_size = cnt_t'(1);
		end else if (int'(cfg_wr_data) > MAX_SIZE) begin
			eff_size = cnt_t'(MAX_SIZE);
		end else begin
			eff_size = cnt_t'(cfg_wr_data);
		end
	end

	assign size_m1       = size_q - cnt_t'(1);
	assign col_inc       = col_q + cnt_t'(1);
	assign first_row_now = (row_q == '0);
	assign last_row_now  = (row_q == size_m1);
	assign last_col_now  = (col_q == size_m1);

	assign rd_addr_a = col_q[AW-1:0];
	assign rd_addr_b = last_col_now ? col_q[AW-1:0] : col_inc[AW-1:0];
	assign wr_addr   = ctrl_s1.col[AW-1:0];

	assign s1_end  = ctrl_s1.last_row && ctrl_s1.last_col;
	// hold the board's last cell while the previous result is still waiting
	assign advance = s1_valid_q && !(s1_end && out_valid_q && !result_out.ready);
	assign in_fire = cell_in.valid && cell_in.ready;

	assign cell_in.ready = !s1_valid_q || advance;

	// three-way maximum over the row above; off-board neighbours count as zero
	always_comb begin
		above_left  = (ctrl_s1.col == '0) ? '0 : left_q;
		above_right = ctrl_s1.last_col ? '0 : rd_b_s1;
		if (ctrl_s1.first_row) begin
			cell_sum = msbp_pkg::sum_t'(value_s1);
		end else begin
			cell_sum = msbp_pkg::sum_t'(value_s1)
				+ msbp_pkg::smax(msbp_pkg::smax(above_left, rd_a_s1), above_right);
		end
		if (ctrl_s1.last_row && (cell_sum > best_q)) begin
			new_best = cell_sum;
			new_col  = ctrl_s1.col + cnt_t'(1);
		end else begin
			new_best = best_q;
			new_col  = best_col_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q      <= cnt_t'(RST_SIZE);
			col_q       <= '0;
			row_q       <= '0;
			best_q      <= '0;
			best_col_q  <= '0;
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				size_q     <= eff_size;
				col_q      <= '0;
				row_q      <= '0;
				best_q     <= '0;
				best_col_q <= '0;
			end else begin
				if (in_fire) begin
					if (last_col_now) begin
						col_q <= '0;
						row_q <= last_row_now ? '0 : row_q + cnt_t'(1);
					end else begin
						col_q <= col_inc;
					end
				end
				if (advance) begin
					if (s1_end) begin
						best_q     <= '0;
						best_col_q <= '0;
					end else begin
						best_q     <= new_best;
						best_col_q <= new_col;
					end
				end
			end

			if (in_fire) begin
				s1_valid_q <= 1'b1;
			end else if (advance) begin
				s1_valid_q <= 1'b0;
			end

			if (advance && s1_end) begin
				out_valid_q <= 1'b1;
			end else if (result_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			value_s1          <= cell_in.cell_value;
			ctrl_s1.first_row <= first_row_now;
			ctrl_s1.last_row  <= last_row_now;
			ctrl_s1.last_col  <= last_col_now;
			ctrl_s1.col       <= col_q;
		end
		if (advance) begin
			left_q <= rd_a_s1;
		end
		if (advance && s1_end) begin
			out_sum_q <= new_best;
			out_col_q <= new_col;
		end
	end

	// row-sum memory; forward the write when a read hits the same entry
	always_ff @(posedge clk) begin
		if (advance) begin
			row_mem[wr_addr] <= cell_sum;
		end
		if (in_fire) begin
			rd_a_s1 <= (advance && (wr_addr == rd_addr_a)) ? cell_sum : row_mem[rd_addr_a];
			rd_b_s1 <= (advance && (wr_addr == rd_addr_b)) ? cell_sum : row_mem[rd_addr_b];
		end
	end

	assign result_out.valid       = out_valid_q;
	assign result_out.best_sum    = out_sum_q;
	assign result_out.best_column = msbp_pkg::col_out_t'(out_col_q);

endmodule

### sim/tb_max_sum_board_path_dp.sv
// Testbench for max_sum_board_path_dp: directed and random boards against a path-sum predictor.
`timescale 1ns / 100ps

module tb_max_sum_board_path_dp;

	localparam int BOARD_MAX     = 64;
	localparam int SETTLE_CYCLES = 4;
	localparam int RANDOM_CELLS  = 230;

	typedef struct packed {
		msbp_pkg::sum_t     best_sum;
		msbp_pkg::col_out_t best_column;
	} board_result_t;

	logic           clk;
	logic           arst_n;
	logic           cfg_wr_en;
	msbp_pkg::cfg_t cfg_wr_data;

	msbp_cell_if   cell_ch();
	msbp_result_if result_ch();

	max_sum_board_path_dp #(
		.MAX_SIZE(BOARD_MAX)
	) DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.cell_in    (cell_ch),
		.result_out (result_ch)
	);

	// Path-sum predictor state
	msbp_pkg::cfg_t     size_reg;
	msbp_pkg::sum_t     above_sums[BOARD_MAX];
	msbp_pkg::sum_t     row_sums[BOARD_MAX];
	int unsigned        row_idx;
	int unsigned        col_idx;
	msbp_pkg::sum_t     lead_sum;
	msbp_pkg::col_out_t lead_col;
	board_result_t      pending_best[$];

	int unsigned error_count;
	int unsigned burst_left;
	bit          gap_mode;
	int unsigned ready_mode;
	int unsigned run_left;
	int unsigned stall_left;

	always #2 clk = ~clk;

	initial begin
		#2_000_000;
		$display("TB_ERROR");
		$finish;
	end

	function automatic int unsigned board_dim();
		if (size_reg == 0)
			return 1;
		if (size_reg > BOARD_MAX)
			return BOARD_MAX;
		return 32'(size_reg);
	endfunction

	function automatic void clear_board_progress();
		row_idx  = 0;
		col_idx  = 0;
		lead_sum = '0;
		lead_col = '0;
	endfunction

	function automatic void step_path_sums(input msbp_pkg::value_t v);
		int unsigned    n;
		msbp_pkg::sum_t s;
		msbp_pkg::sum_t up_left;
		msbp_pkg::sum_t up_right;
		msbp_pkg::sum_t up_best;
		board_result_t  done;
		n = board_dim();
		if (row_idx == 0) begin
			s = msbp_pkg::sum_t'(v);
		end else begin
			// neighbours beyond the board edge count as zero
			up_left  = (col_idx > 0) ? above_sums[col_idx - 1] : '0;
			up_right = (col_idx + 1 < n) ? above_sums[col_idx + 1] : '0;
			up_best  = above_sums[col_idx];
			if (up_left > up_best)
				up_best = up_left;
			if (up_right > up_best)
				up_best = up_right;
			s = up_best + msbp_pkg::sum_t'(v);
		end
		row_sums[col_idx] = s;
		if (row_idx + 1 == n && s > lead_sum) begin
			lead_sum = s;
			lead_col = msbp_pkg::col_out_t'(col_idx + 1);
		end
		if (col_idx + 1 < n) begin
			col_idx++;
		end else begin
			col_idx = 0;
			if (row_idx + 1 < n) begin
				above_sums = row_sums;
				row_idx++;
			end else begin
				done.best_sum    = lead_sum;
				done.best_column = lead_col;
				pending_best.push_back(done);
				clear_board_progress();
			end
		end
	endfunction

	function automatic void note_error(input string what);
		error_count++;
		if (error_count <= 10)
			$display("%t mismatch: %s", $time, what);
	endfunction

	function automatic msbp_pkg::value_t rand_cell();
		msbp_pkg::value_t v;
		case ($urandom_range(0, 9))
			0: v = 16'sh7fff;
			1: v = 16'sh8000;
			2, 3: begin
				v = msbp_pkg::value_t'($urandom_range(0, 6));
				v = v - 16'sd3;
			end
			default: v = msbp_pkg::value_t'($urandom);
		endcase
		return v;
	endfunction

	// Receiver: mode 0 is always ready; else runs of ready broken by stalls, mode 2 stalls for longer
	always @(negedge clk) begin
		if (ready_mode == 0) begin
			result_ch.ready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			result_ch.ready <= 1'b0;
		end else if (run_left > 0) begin
			run_left--;
			result_ch.ready <= 1'b1;
		end else begin
			run_left   = $urandom_range(0, 6);
			stall_left = (ready_mode == 2) ? $urandom_range(4, 20) : $urandom_range(0, 2);
			result_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin : check_result
		board_result_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (pending_best.size() == 0) begin
				note_error($sformatf("unexpected result: best_sum %0d best_column %0d",
					result_ch.best_sum, result_ch.best_column));
			end else begin
				want = pending_best.pop_front();
				if (result_ch.best_sum !== want.best_sum)
					note_error($sformatf("best_sum expected %0d, got %0d",
						want.best_sum, result_ch.best_sum));
				if (result_ch.best_column !== want.best_column)
					note_error($sformatf("best_column expected %0d, got %0d",
						want.best_column, result_ch.best_column));
			end
		end
	end

	task automatic send_cell(input msbp_pkg::value_t v);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if (gap_mode && $urandom_range(0, 3) != 0) begin
				@(negedge clk);
				cell_ch.valid <= 1'b0;
				repeat ($urandom_range(0, 5)) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		cell_ch.valid      <= 1'b1;
		cell_ch.cell_value <= v;
		@(posedge clk);
		while (!cell_ch.ready)
			@(posedge clk);
		step_path_sums(v);
	endtask

	task automatic send_random_cells(input int unsigned count);
		repeat (count)
			send_cell(rand_cell());
	endtask

	// Hold the sender until every expected result has been taken
	task automatic pause_cells();
		@(negedge clk);
		cell_ch.valid <= 1'b0;
		while (pending_best.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_board_size(input msbp_pkg::cfg_t code);
		pause_cells();
		// let a cell that produces no result clear the pipeline
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= code;
		@(posedge clk);
		size_reg = code;
		clear_board_progress();
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic test_default_size();
		gap_mode   = 1'b1;
		ready_mode = 1;
		send_random_cells(msbp_pkg::RESET_SIZE * msbp_pkg::RESET_SIZE);
	endtask

	task automatic test_single_cell_boards();
		gap_mode   = 1'b0;
		ready_mode = 0;
		write_board_size(msbp_pkg::cfg_t'(1));
		send_cell(16'sh7fff);
		send_cell(16'sh8000);
		send_cell(16'sd0);
		send_cell(16'sd1);
		// size zero behaves as a single cell
		write_board_size(msbp_pkg::cfg_t'(0));
		send_cell(16'sd7);
	endtask

	task automatic test_two_by_two();
		gap_mode   = 1'b1;
		ready_mode = 2;
		write_board_size(msbp_pkg::cfg_t'(2));
		// equal sums: first column wins
		send_cell(16'sd3);
		send_cell(16'sd3);
		send_cell(16'sd1);
		send_cell(16'sd1);
		// nothing positive: zero sum, column zero
		repeat (4)
			send_cell(16'sh8000);
		send_cell(16'sd10);
		send_cell(-16'sd5);
		send_cell(-16'sd5);
		send_cell(16'sd2);
	endtask

	task automatic test_abandoned_board();
		gap_mode   = 1'b1;
		ready_mode = 1;
		write_board_size(msbp_pkg::cfg_t'(3));
		send_random_cells(5);
		write_board_size(msbp_pkg::cfg_t'(2));
		send_random_cells(4);
	endtask

	task automatic test_largest_board();
		gap_mode   = 1'b0;
		ready_mode = 1;
		// above the maximum: clamps to the largest board; run two full rows into the third
		write_board_size(msbp_pkg::cfg_t'(127));
		send_random_cells(2 * BOARD_MAX + 2);
	endtask

	task automatic test_random_boards();
		int unsigned    sent;
		int unsigned    boards_left;
		int unsigned    cells;
		int unsigned    pick;
		msbp_pkg::cfg_t code;
		sent        = 0;
		boards_left = 0;
		while (sent < RANDOM_CELLS) begin
			if (boards_left == 0) begin
				pick = $urandom_range(0, 19);
				if (pick < 3)
					code = msbp_pkg::cfg_t'(1);
				else if (pick < 15)
					code = msbp_pkg::cfg_t'($urandom_range(2, 5));
				else if (pick < 18)
					code = msbp_pkg::cfg_t'($urandom_range(6, 9));
				else if (pick == 18)
					code = msbp_pkg::cfg_t'(0);
				else
					code = msbp_pkg::cfg_t'($urandom_range(10, 12));
				write_board_size(code);
				boards_left = $urandom_range(1, 4);
			end
			gap_mode   = ($urandom_range(0, 3) != 0);
			ready_mode = $urandom_range(0, 2);
			cells = board_dim() * board_dim();
			// cut a board short now and then; the next size write drops it
			if (cells > 1 && $urandom_range(0, 7) == 0) begin
				cells       = $urandom_range(1, cells - 1);
				boards_left = 1;
			end
			send_random_cells(cells);
			sent += cells;
			boards_left--;
			if ($urandom_range(0, 5) == 0)
				pause_cells();
		end
	endtask

	initial begin
		clk                = 1'b0;
		arst_n             = 1'b0;
		cfg_wr_en          = 1'b0;
		cfg_wr_data        = '0;
		cell_ch.valid      = 1'b0;
		cell_ch.cell_value = '0;
		result_ch.ready    = 1'b0;
		error_count        = 0;
		burst_left         = 0;
		gap_mode           = 1'b0;
		ready_mode         = 0;
		run_left           = 0;
		stall_left         = 0;
		size_reg           = msbp_pkg::cfg_t'(msbp_pkg::RESET_SIZE);
		clear_board_progress();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_default_size();
		test_single_cell_boards();
		test_two_by_two();
		test_abandoned_board();
		test_largest_board();
		test_random_boards();

		pause_cells();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0 && pending_best.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
